/* rtl/core/dnmc_pkg.sv */
// day/night mode controller package: codes, counter type and compare helpers
// used by the controller core; depends on nothing else
package dnmc_pkg;

  // run counter, threshold, compare and config port widths
  localparam int CNT_W  = 8;
  localparam int THR_W  = 8;
  localparam int CMP_W  = (CNT_W > THR_W) ? CNT_W : THR_W;
  localparam int CFG_IW = 3;
  localparam int CFG_DW = 8;

  typedef logic [CNT_W-1:0] cnt_t;
  typedef logic [THR_W-1:0] thr_t;

  // light state codes
  typedef enum logic [1:0] {
    ST_DAY    = 2'd0,
    ST_NIGHT  = 2'd1,
    ST_DARK   = 2'd2,
    ST_LOWLUX = 2'd3
  } light_state_t;

  // operating modes
  typedef enum logic [1:0] {
    MODE_AUTO         = 2'd0,
    MODE_FORCED_NIGHT = 2'd1,
    MODE_FORCED_DAY   = 2'd2
  } mode_t;

  // light sensor levels
  typedef enum logic [1:0] {
    LL_BRIGHT  = 2'd0,
    LL_DARK    = 2'd1,
    LL_NEITHER = 2'd2
  } light_level_t;

  // bitrate levels
  typedef enum logic [1:0] {
    BR_NORMAL  = 2'd0,
    BR_BETWEEN = 2'd1,
    BR_HIGH    = 2'd2
  } bitrate_level_t;

  // encoder control codes
  typedef enum logic [1:0] {
    CTL_NONE     = 2'd0,
    CTL_CONTROL  = 2'd1,
    CTL_RECOVERY = 2'd2
  } ctl_t;

  // configuration register indexes
  typedef enum logic [CFG_IW-1:0] {
    REG_MODE            = 3'd0,
    REG_NIGHT_ENTER     = 3'd1,
    REG_DAY_ENTER       = 3'd2,
    REG_LOWLUX_ENTER    = 3'd3,
    REG_LOWLUX_EXIT     = 3'd4,
    REG_BITRATE_OVER    = 3'd5,
    REG_BITRATE_RECOVER = 3'd6
  } reg_idx_t;

  // saturating increment of a run counter
  function automatic cnt_t sat_inc(cnt_t c);
    return (c == {CNT_W{1'b1}}) ? c : cnt_t'(c + 1'b1);
  endfunction

  // run counter strictly above its threshold
  function automatic logic cnt_gt(cnt_t c, thr_t t);
    logic [CMP_W-1:0] cx;
    logic [CMP_W-1:0] tx;
    cx = CMP_W'(c);
    tx = CMP_W'(t);
    return cx > tx;
  endfunction

endpackage

/* rtl/core/day_night_mode_controller.sv */
// day/night mode controller: debounce counters, low-lux tracking and bitrate
// control stepping, one tick per transfer; depends on dnmc_pkg
//
// channel  | ports                                         | handshake
// ---------+-----------------------------------------------+----------------
// input    | in_light_level in_isp_day_flag in_bitrate_level | in_valid/in_ready
//          | in_encoder_control                            |
// result   | out_light_state out_state_changed             | out_valid/out_ready
//          | out_control_command out_control_changed       |
// config   | cfg_index cfg_wdata                           | cfg_we, no wait
//
// one tick per cycle sustained while out_ready stays high; a tick's result is
// registered in the input register and then in the result register fed by the
// update logic before it reaches the result ports
// the result register lets a new tick enter while a result waits; a full
// result register with out_ready low stalls the input register
// reset (synchronous, rst_n low) loads the register defaults and clears state
module day_night_mode_controller
  import dnmc_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  // input channel
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [1:0]          in_light_level,
  input  logic                in_isp_day_flag,
  input  logic [1:0]          in_bitrate_level,
  input  logic [1:0]          in_encoder_control,
  // result channel
  output logic                out_valid,
  input  logic                out_ready,
  output logic [1:0]          out_light_state,
  output logic                out_state_changed,
  output logic [1:0]          out_control_command,
  output logic                out_control_changed,
  // configuration port
  input  logic                cfg_we,
  input  logic [CFG_IW-1:0]   cfg_index,
  input  logic [CFG_DW-1:0]   cfg_wdata
);

  // configuration registers
  logic [1:0] mode_r;
  thr_t       night_enter_r;
  thr_t       day_enter_r;
  thr_t       lowlux_enter_r;
  thr_t       lowlux_exit_r;
  thr_t       br_over_thr_r;
  thr_t       br_recover_thr_r;

  // input stage
  logic       s1_valid_r;
  logic [1:0] s1_light_r;
  logic       s1_isp_day_r;
  logic [1:0] s1_level_r;
  logic [1:0] s1_ctl_r;

  // controller state
  light_state_t state_r, state_nxt;
  cnt_t night_run_r, night_run_nxt;
  cnt_t day_run_r, day_run_nxt;
  cnt_t lowlux_run_r, lowlux_run_nxt;
  cnt_t lowlux_rec_r, lowlux_rec_nxt;
  cnt_t br_over_r, br_over_nxt;
  cnt_t br_rec_r, br_rec_nxt;

  // per-tick command
  logic [1:0] cmd_nxt;
  logic       cmd_chg_nxt;
  logic [1:0] ctl_new;

  // result register
  logic       out_valid_r;
  logic [1:0] out_state_r;
  logic       out_state_chg_r;
  logic [1:0] out_cmd_r;
  logic       out_cmd_chg_r;

  logic advance;
  logic s1_fire;
  logic in_fire;

  // pipeline flow control
  assign advance  = !out_valid_r || out_ready;
  assign s1_fire  = s1_valid_r && advance;
  assign in_ready = !s1_valid_r || advance;
  assign in_fire  = in_valid && in_ready;

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r           <= MODE_AUTO;
      night_enter_r    <= thr_t'(2);
      day_enter_r      <= thr_t'(2);
      lowlux_enter_r   <= thr_t'(6);
      lowlux_exit_r    <= thr_t'(8);
      br_over_thr_r    <= thr_t'(6);
      br_recover_thr_r <= thr_t'(12);
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_MODE:            mode_r           <= cfg_wdata[1:0];
        REG_NIGHT_ENTER:     night_enter_r    <= cfg_wdata[THR_W-1:0];
        REG_DAY_ENTER:       day_enter_r      <= cfg_wdata[THR_W-1:0];
        REG_LOWLUX_ENTER:    lowlux_enter_r   <= cfg_wdata[THR_W-1:0];
        REG_LOWLUX_EXIT:     lowlux_exit_r    <= cfg_wdata[THR_W-1:0];
        REG_BITRATE_OVER:    br_over_thr_r    <= cfg_wdata[THR_W-1:0];
        REG_BITRATE_RECOVER: br_recover_thr_r <= cfg_wdata[THR_W-1:0];
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_light_r   <= in_light_level;
      s1_isp_day_r <= in_isp_day_flag;
      s1_level_r   <= in_bitrate_level;
      s1_ctl_r     <= in_encoder_control;
    end
  end

  // next state and counter update
  always_comb begin
    state_nxt      = state_r;
    night_run_nxt  = night_run_r;
    day_run_nxt    = day_run_r;
    lowlux_run_nxt = lowlux_run_r;
    lowlux_rec_nxt = lowlux_rec_r;
    br_over_nxt    = br_over_r;
    br_rec_nxt     = br_rec_r;
    ctl_new        = s1_ctl_r;
    unique case (mode_r)
      MODE_AUTO: begin
        // night/day debounce
        case (s1_light_r)
          LL_DARK: begin
            night_run_nxt = sat_inc(night_run_r);
            day_run_nxt   = '0;
          end
          LL_BRIGHT: begin
            night_run_nxt = '0;
            day_run_nxt   = sat_inc(day_run_r);
          end
          default: ;
        endcase
        if (cnt_gt(night_run_nxt, night_enter_r)) begin
          state_nxt = ST_NIGHT;
        end else if (cnt_gt(day_run_nxt, day_enter_r)) begin
          state_nxt = ST_DAY;
        end

        // low-lux tracking outside night
        if (state_nxt != ST_NIGHT) begin
          if (!s1_isp_day_r) begin
            lowlux_run_nxt = sat_inc(lowlux_run_r);
            lowlux_rec_nxt = '0;
          end else if (state_r == ST_LOWLUX) begin
            lowlux_run_nxt = '0;
            lowlux_rec_nxt = sat_inc(lowlux_rec_r);
          end else begin
            lowlux_run_nxt = '0;
            lowlux_rec_nxt = '0;
          end
          if (cnt_gt(lowlux_run_nxt, lowlux_enter_r) && state_r == ST_DAY) begin
            state_nxt = ST_LOWLUX;
          end else if (cnt_gt(lowlux_rec_nxt, lowlux_exit_r)) begin
            state_nxt = ST_DAY;
          end else if (state_r == ST_LOWLUX) begin
            state_nxt = ST_LOWLUX;
          end
        end

        // bitrate control stepping
        if (s1_ctl_r != CTL_CONTROL && s1_level_r >= BR_HIGH) begin
          br_over_nxt = sat_inc(br_over_r);
          br_rec_nxt  = '0;
        end else if (s1_ctl_r != CTL_NONE && s1_level_r == BR_NORMAL) begin
          br_over_nxt = '0;
          br_rec_nxt  = sat_inc(br_rec_r);
        end else begin
          br_over_nxt = '0;
          br_rec_nxt  = '0;
        end
        if (cnt_gt(br_over_nxt, br_over_thr_r)) begin
          ctl_new = CTL_CONTROL;
        end else if (cnt_gt(br_rec_nxt, br_recover_thr_r)) begin
          ctl_new = (s1_ctl_r == CTL_RECOVERY) ? CTL_NONE : CTL_RECOVERY;
        end
        if (ctl_new != s1_ctl_r) begin
          br_over_nxt = '0;
          br_rec_nxt  = '0;
        end
      end
      MODE_FORCED_NIGHT: state_nxt = ST_NIGHT;
      MODE_FORCED_DAY:   state_nxt = ST_DAY;
      default: ;
    endcase
  end

  // command output for the tick
  always_comb begin
    cmd_chg_nxt = (mode_r == MODE_AUTO) && (ctl_new != s1_ctl_r);
    cmd_nxt     = cmd_chg_nxt ? ctl_new : CTL_NONE;
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_DAY;
      night_run_r  <= '0;
      day_run_r    <= '0;
      lowlux_run_r <= '0;
      lowlux_rec_r <= '0;
      br_over_r    <= '0;
      br_rec_r     <= '0;
    end else if (s1_fire) begin
      state_r      <= state_nxt;
      night_run_r  <= night_run_nxt;
      day_run_r    <= day_run_nxt;
      lowlux_run_r <= lowlux_run_nxt;
      lowlux_rec_r <= lowlux_rec_nxt;
      br_over_r    <= br_over_nxt;
      br_rec_r     <= br_rec_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      out_state_r     <= state_nxt;
      out_state_chg_r <= (state_nxt != state_r);
      out_cmd_r       <= cmd_nxt;
      out_cmd_chg_r   <= cmd_chg_nxt;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_light_state     = out_state_r;
  assign out_state_changed   = out_state_chg_r;
  assign out_control_command = out_cmd_r;
  assign out_control_changed = out_cmd_chg_r;

endmodule

/* tb/day_night_mode_checker.sv */
// result checker for the day/night mode controller: snoops the input, result and
// config ports, predicts every tick's result and compares it field by field
// depends on dnmc_pkg for codes and the run counter type
module day_night_mode_checker
  import dnmc_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_ready,
  input  logic [1:0]        in_light_level,
  input  logic              in_isp_day_flag,
  input  logic [1:0]        in_bitrate_level,
  input  logic [1:0]        in_encoder_control,
  input  logic              out_valid,
  input  logic              out_ready,
  input  logic [1:0]        out_light_state,
  input  logic              out_state_changed,
  input  logic [1:0]        out_control_command,
  input  logic              out_control_changed,
  input  logic              cfg_we,
  input  logic [CFG_IW-1:0] cfg_index,
  input  logic [CFG_DW-1:0] cfg_wdata,
  output int                fail_count,
  output int                pending,
  output int                ticks_seen,
  output int                state_flips,
  output int                commands_seen
);

  typedef struct packed {
    logic [1:0] light_state;
    logic       state_changed;
    logic [1:0] control_command;
    logic       control_changed;
  } tick_result_t;

  // shadow of the register file
  logic [1:0] mode_q;
  thr_t       night_thr, day_thr, lowlux_in_thr, lowlux_out_thr, over_thr, recover_thr;

  // predicted controller state
  logic [1:0] cur_state;
  cnt_t       night_run, day_run, lowlux_run, lowlux_recover_run;
  cnt_t       over_run, recover_run;

  tick_result_t expected_ticks[$];

  // run counter step, holding at all ones
  function automatic cnt_t bump(cnt_t c);
    return (&c) ? c : cnt_t'(c + 1);
  endfunction

  // one tick of the controller: updates the shadow state, returns the result
  task automatic predict_tick(input logic [1:0] light, input logic isp_day,
                              input logic [1:0] level, input logic [1:0] ctl_last,
                              output tick_result_t r);
    logic [1:0] prev;
    logic [1:0] nxt;
    logic [1:0] ctl_new;
    prev = cur_state;
    nxt  = prev;
    r    = '0;
    if (mode_q == MODE_AUTO) begin
      ctl_new = ctl_last;
      // light sensor debounce
      if (light == LL_DARK) begin
        night_run = bump(night_run);
        day_run   = '0;
      end else if (light == LL_BRIGHT) begin
        night_run = '0;
        day_run   = bump(day_run);
      end
      if (night_run > night_thr) nxt = ST_NIGHT;
      else if (day_run > day_thr) nxt = ST_DAY;
      // low-lux tracking from the image processor flag, outside night
      if (nxt != ST_NIGHT) begin
        if (!isp_day) begin
          lowlux_run         = bump(lowlux_run);
          lowlux_recover_run = '0;
        end else if (prev == ST_LOWLUX) begin
          lowlux_run         = '0;
          lowlux_recover_run = bump(lowlux_recover_run);
        end else begin
          lowlux_run         = '0;
          lowlux_recover_run = '0;
        end
        if (lowlux_run > lowlux_in_thr && prev == ST_DAY) nxt = ST_LOWLUX;
        else if (lowlux_recover_run > lowlux_out_thr) nxt = ST_DAY;
        else if (prev == ST_LOWLUX) nxt = ST_LOWLUX;
      end
      // bitrate control stepping
      if (ctl_last != CTL_CONTROL && level >= BR_HIGH) begin
        over_run    = bump(over_run);
        recover_run = '0;
      end else if (ctl_last != CTL_NONE && level == BR_NORMAL) begin
        over_run    = '0;
        recover_run = bump(recover_run);
      end else begin
        over_run    = '0;
        recover_run = '0;
      end
      if (over_run > over_thr) ctl_new = CTL_CONTROL;
      else if (recover_run > recover_thr)
        ctl_new = (ctl_last == CTL_RECOVERY) ? CTL_NONE : CTL_RECOVERY;
      if (ctl_new != ctl_last) begin
        over_run          = '0;
        recover_run       = '0;
        r.control_command = ctl_new;
        r.control_changed = 1'b1;
      end
    end else if (mode_q == MODE_FORCED_DAY) begin
      nxt = ST_DAY;
    end else if (mode_q == MODE_FORCED_NIGHT) begin
      nxt = ST_NIGHT;
    end
    // any other mode freezes everything
    cur_state       = nxt;
    r.light_state   = nxt;
    r.state_changed = (nxt != prev);
  endtask

  task automatic check_field(input string name, input int want, input int got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endtask

  // snoop config writes and both channels' transfers
  always @(posedge clk) begin
    tick_result_t want;
    tick_result_t got;
    if (!rst_n) begin
      mode_q             = MODE_AUTO;
      night_thr          = 8'd2;
      day_thr            = 8'd2;
      lowlux_in_thr      = 8'd6;
      lowlux_out_thr     = 8'd8;
      over_thr           = 8'd6;
      recover_thr        = 8'd12;
      cur_state          = ST_DAY;
      night_run          = '0;
      day_run            = '0;
      lowlux_run         = '0;
      lowlux_recover_run = '0;
      over_run           = '0;
      recover_run        = '0;
      expected_ticks.delete();
      fail_count         = 0;
      pending            = 0;
      ticks_seen         = 0;
      state_flips        = 0;
      commands_seen      = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_MODE:            mode_q         = cfg_wdata[1:0];
          REG_NIGHT_ENTER:     night_thr      = cfg_wdata;
          REG_DAY_ENTER:       day_thr        = cfg_wdata;
          REG_LOWLUX_ENTER:    lowlux_in_thr  = cfg_wdata;
          REG_LOWLUX_EXIT:     lowlux_out_thr = cfg_wdata;
          REG_BITRATE_OVER:    over_thr       = cfg_wdata;
          REG_BITRATE_RECOVER: recover_thr    = cfg_wdata;
          default: ;
        endcase
      end
      // result transfer against the oldest outstanding tick
      if (out_valid && out_ready) begin
        got = '{out_light_state, out_state_changed, out_control_command,
                out_control_changed};
        if (expected_ticks.size() == 0) begin
          $error("result transfer with no tick outstanding");
          fail_count++;
        end else begin
          want = expected_ticks.pop_front();
          check_field("light_state", want.light_state, got.light_state);
          check_field("state_changed", want.state_changed, got.state_changed);
          check_field("control_command", want.control_command, got.control_command);
          check_field("control_changed", want.control_changed, got.control_changed);
        end
      end
      // input transfer: predict its result
      if (in_valid && in_ready) begin
        predict_tick(in_light_level, in_isp_day_flag, in_bitrate_level,
                     in_encoder_control, want);
        expected_ticks.push_back(want);
        ticks_seen++;
        if (want.state_changed) state_flips++;
        if (want.control_changed) commands_seen++;
      end
      pending = expected_ticks.size();
    end
  end

endmodule

/* tb/day_night_mode_controller_test.sv */
// testbench top for the day/night mode controller: clock, reset, register
// settings, tick stimulus and result back-pressure, plus the verdict
// depends on dnmc_pkg, day_night_mode_controller and day_night_mode_checker
module day_night_mode_controller_test
  import dnmc_pkg::*;
();

  // codes outside the named ranges
  localparam logic [1:0]        LIGHT_RSVD = 2'd3;
  localparam logic [1:0]        LEVEL_RSVD = 2'd3;
  localparam logic [1:0]        CTL_RSVD   = 2'd3;
  localparam logic [1:0]        MODE_FROZEN = 2'd3;
  localparam logic [CFG_IW-1:0] REG_UNUSED = 3'd7;
  localparam int                LONG_HOLD_CYCLES = 300;

  typedef struct packed {
    logic [1:0] light;
    logic       isp;
    logic [1:0] level;
    logic [1:0] ctl;
  } tick_t;

  typedef struct packed {
    logic [1:0] mode;
    logic [7:0] night;
    logic [7:0] day;
    logic [7:0] ll_in;
    logic [7:0] ll_out;
    logic [7:0] br_over;
    logic [7:0] br_rec;
  } settings_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic [1:0]        in_light_level = '0;
  logic              in_isp_day_flag = 1'b0;
  logic [1:0]        in_bitrate_level = '0;
  logic [1:0]        in_encoder_control = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [1:0]        out_light_state;
  logic              out_state_changed;
  logic [1:0]        out_control_command;
  logic              out_control_changed;
  logic              cfg_we = 1'b0;
  logic [CFG_IW-1:0] cfg_index = '0;
  logic [CFG_DW-1:0] cfg_wdata = '0;

  int fail_count, pending, ticks_seen, state_flips, commands_seen;
  int settings_loaded = 0;
  bit long_hold_go = 1'b0;

  day_night_mode_controller dut (.*);
  day_night_mode_checker chk (.*);

  initial forever #6 clk = ~clk;

  // overall time limit
  initial begin
    #3000000;
    $display("day_night_mode_controller_test NOT OK");
    $finish;
  end

  // one tick transfer; ready is looked at mid-cycle, away from the edge
  task automatic send_tick(input tick_t t);
    logic took;
    in_valid           <= 1'b1;
    in_light_level     <= t.light;
    in_isp_day_flag    <= t.isp;
    in_bitrate_level   <= t.level;
    in_encoder_control <= t.ctl;
    do begin
      @(negedge clk);
      took = in_ready;
      @(posedge clk);
    end while (!took);
  endtask

  // leaves cfg_we high; the caller lowers it after the last write
  task automatic put_reg(input logic [CFG_IW-1:0] idx, input logic [7:0] v);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= v;
    @(posedge clk);
  endtask

  task automatic load_settings(input settings_t s, input bit poke_unused);
    put_reg(REG_MODE, {6'($urandom), s.mode});
    put_reg(REG_NIGHT_ENTER, s.night);
    put_reg(REG_DAY_ENTER, s.day);
    put_reg(REG_LOWLUX_ENTER, s.ll_in);
    put_reg(REG_LOWLUX_EXIT, s.ll_out);
    put_reg(REG_BITRATE_OVER, s.br_over);
    put_reg(REG_BITRATE_RECOVER, s.br_rec);
    if (poke_unused) put_reg(REG_UNUSED, 8'($urandom));
    cfg_we <= 1'b0;
    settings_loaded++;
  endtask

  // stop offering and wait until every result has come out
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  function automatic tick_t fresh_tick();
    tick_t t;
    int    r;
    r = $urandom_range(0, 99);
    t.light = (r < 40) ? LL_BRIGHT : (r < 80) ? LL_DARK : (r < 92) ? LL_NEITHER : LIGHT_RSVD;
    r = $urandom_range(0, 99);
    t.level = (r < 40) ? BR_NORMAL : (r < 60) ? BR_BETWEEN : (r < 90) ? BR_HIGH : LEVEL_RSVD;
    r = $urandom_range(0, 99);
    t.ctl = (r < 30) ? CTL_NONE : (r < 60) ? CTL_CONTROL : (r < 90) ? CTL_RECOVERY : CTL_RSVD;
    t.isp = 1'($urandom);
    return t;
  endfunction

  function automatic settings_t spread_settings(input logic [1:0] m, input int hi);
    settings_t s;
    s.mode    = m;
    s.night   = 8'($urandom_range(0, hi));
    s.day     = 8'($urandom_range(0, hi));
    s.ll_in   = 8'($urandom_range(0, hi));
    s.ll_out  = 8'($urandom_range(0, hi));
    s.br_over = 8'($urandom_range(0, hi));
    s.br_rec  = 8'($urandom_range(0, hi));
    return s;
  endfunction

  // result side back-pressure: stretches of different stall patterns
  initial begin
    int  n;
    int  style;
    bit  held;
    held = 1'b0;
    @(posedge clk);
    forever begin
      if (long_hold_go && !held) begin
        held = 1'b1;
        out_ready <= 1'b0;
        for (int k = 0; k < LONG_HOLD_CYCLES; k++) @(posedge clk);
      end
      style = $urandom_range(0, 3);
      n     = $urandom_range(4, 60);
      for (int k = 0; k < n; k++) begin
        case (style)
          0: out_ready <= 1'b1;
          1: out_ready <= 1'($urandom);
          2: out_ready <= ($urandom_range(0, 4) == 0);
          default: out_ready <= k[0];
        endcase
        @(posedge clk);
      end
    end
  end

  // stimulus
  initial begin
    settings_t s;
    tick_t     hold_t;
    tick_t     t;
    int        seg_left, burst_left, gap, max_gap, long_pct, n_items;
    bit        quiet_seg;

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset thresholds: night after the third dark tick
    repeat (3) send_tick('{LL_DARK, 1'b1, BR_NORMAL, CTL_NONE});
    drain_results();

    // zero thresholds so every rule fires on its first tick
    load_settings('{MODE_AUTO, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0}, 1'b0);
    send_tick('{LL_DARK, 1'b1, BR_NORMAL, CTL_NONE});
    send_tick('{LL_BRIGHT, 1'b1, BR_HIGH, CTL_NONE});
    send_tick('{LL_BRIGHT, 1'b0, LEVEL_RSVD, CTL_NONE});
    send_tick('{LL_NEITHER, 1'b1, BR_BETWEEN, CTL_CONTROL});
    send_tick('{LIGHT_RSVD, 1'b0, BR_NORMAL, CTL_CONTROL});
    send_tick('{LL_DARK, 1'b0, BR_NORMAL, CTL_RECOVERY});
    send_tick('{LL_BRIGHT, 1'b0, BR_NORMAL, CTL_RSVD});
    send_tick('{LL_NEITHER, 1'b1, BR_HIGH, CTL_CONTROL});
    send_tick('{LL_BRIGHT, 1'b1, LEVEL_RSVD, CTL_RSVD});
    send_tick('{LIGHT_RSVD, 1'b1, BR_BETWEEN, CTL_RECOVERY});
    drain_results();

    // forced modes and the frozen mode
    load_settings('{MODE_FORCED_NIGHT, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0}, 1'b0);
    send_tick('{LL_BRIGHT, 1'b1, BR_HIGH, CTL_NONE});
    send_tick('{LL_BRIGHT, 1'b0, BR_NORMAL, CTL_RECOVERY});
    drain_results();
    load_settings('{MODE_FORCED_DAY, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0}, 1'b0);
    send_tick('{LL_DARK, 1'b0, BR_HIGH, CTL_NONE});
    send_tick('{LL_DARK, 1'b1, BR_NORMAL, CTL_CONTROL});
    drain_results();
    load_settings('{MODE_FROZEN, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0}, 1'b0);
    send_tick('{LL_DARK, 1'b0, BR_HIGH, CTL_NONE});
    send_tick('{LL_BRIGHT, 1'b1, LEVEL_RSVD, CTL_RSVD});
    drain_results();

    // random phases: held segments with some noise, under varied settings
    for (int ph = 0; ph < 10; ph++) begin
      n_items  = 200;
      max_gap  = $urandom_range(2, 12);
      long_pct = 8;
      case (ph)
        0: s = spread_settings(MODE_AUTO, 10);
        1: begin
          s = '{MODE_AUTO, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0};
          max_gap = 0;
        end
        2: begin
          s = '{MODE_AUTO, 8'd254, 8'd254, 8'd254, 8'd254, 8'd254, 8'd254};
          n_items  = 400;
          long_pct = 45;
        end
        3: begin
          s = spread_settings(MODE_FORCED_NIGHT, 255);
          n_items = 100;
        end
        4: s = spread_settings(MODE_AUTO, 40);
        5: begin
          s = spread_settings(MODE_FORCED_DAY, 255);
          n_items = 100;
        end
        6: begin
          s = spread_settings(MODE_FROZEN, 255);
          n_items = 100;
        end
        7: begin
          s = '{MODE_AUTO, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255};
          long_pct = 45;
        end
        8: s = '{MODE_AUTO, 8'd2, 8'd2, 8'd6, 8'd8, 8'd6, 8'd12};
        default: begin
          s = spread_settings(MODE_AUTO, 6);
          max_gap = 0;
        end
      endcase
      load_settings(s, ph == 7);
      if (ph == 4) long_hold_go = 1'b1;

      seg_left   = 0;
      burst_left = $urandom_range(1, 50);
      for (int i = 0; i < n_items; i++) begin
        // new held segment, sometimes long enough to saturate the counters
        if (seg_left == 0) begin
          hold_t    = fresh_tick();
          quiet_seg = ($urandom_range(0, 99) < long_pct);
          seg_left  = quiet_seg ? $urandom_range(200, 320) : $urandom_range(1, 20);
        end
        t = hold_t;
        if (!quiet_seg) begin
          if ($urandom_range(0, 7) == 0) t.light = 2'($urandom);
          if ($urandom_range(0, 7) == 0) t.isp = 1'($urandom);
          if ($urandom_range(0, 7) == 0) t.level = 2'($urandom);
          if ($urandom_range(0, 7) == 0) t.ctl = 2'($urandom);
        end
        seg_left--;
        // sender bursts with idle gaps between them
        if (burst_left == 0) begin
          gap = $urandom_range(0, max_gap);
          if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
          end
          burst_left = $urandom_range(1, 50);
        end
        burst_left--;
        send_tick(t);
      end
      drain_results();
    end

    $display("covered %0d ticks under %0d register settings, all modes and codes",
             ticks_seen, settings_loaded);
    $display("%0d light state changes and %0d encoder control commands seen",
             state_flips, commands_seen);
    if (fail_count == 0) begin
      $display("day_night_mode_controller_test OK");
    end else begin
      $display("day_night_mode_controller_test NOT OK");
    end
    $finish;
  end

endmodule
